// File: rtl/core/mpss_pkg.sv
package mpss_pkg;

    localparam int PAT_BYTES        = 8;
    localparam int PAT_W            = 8 * PAT_BYTES;
    localparam int LEN_W            = 4;
    localparam int BUILTIN_COUNT    = 6;
    localparam int DEF_MAX_PATTERNS = 64;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_SCAN  = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [2:0] KIND_ADDED   = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_CLEAN   = 3'd2;
    localparam logic [2:0] KIND_HIT     = 3'd3;
    localparam logic [2:0] KIND_CLEARED = 3'd4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic scan;
        logic shift;
        logic clear;
    } cell_ctl_t;

    // Built-in patterns, first byte in the lowest byte.
    function automatic logic [PAT_W-1:0] builtin_pat(input int idx);
        logic [PAT_W-1:0] p;
        case (idx)
            0:       p = 64'h0000_0000_006D_723B;   // ;rm
            1:       p = 64'h0000_0000_0068_737C;   // |sh
            2:       p = 64'h0000_0000_002F_2E2E;   // ../
            3:       p = 64'h0000_0000_0000_6E25;   // %n
            4:       p = 64'h6564_756C_636E_6923;   // #include
            5:       p = 64'h0065_6E69_6665_6423;   // #define
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic logic [LEN_W-1:0] builtin_len(input int idx);
        logic [LEN_W-1:0] n;
        case (idx)
            0:       n = 4'd3;
            1:       n = 4'd3;
            2:       n = 4'd3;
            3:       n = 4'd2;
            4:       n = 4'd8;
            5:       n = 4'd7;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // Stored length: requested length capped at the pattern width, cut at the first zero byte.
    function automatic logic [LEN_W-1:0] pattern_len(input logic [PAT_W-1:0] pbytes,
                                                     input logic [LEN_W-1:0] plen);
        logic [LEN_W-1:0] n;
        logic [LEN_W-1:0] k;
        logic             stop;
        n    = (plen > LEN_W'(PAT_BYTES)) ? LEN_W'(PAT_BYTES) : plen;
        k    = '0;
        stop = 1'b0;
        for (int j = 0; j < PAT_BYTES; j++) begin
            if (!stop && (LEN_W'(j) < n)) begin
                if (pbytes[8*j +: 8] == 8'd0) begin
                    stop = 1'b1;
                end else begin
                    k = k + LEN_W'(1);
                end
            end
        end
        return k;
    endfunction

    // Window byte 0 is the newest; pattern byte k lines up with window byte len-1-k.
    function automatic logic cell_match(input logic [PAT_W-1:0] pat,
                                        input logic [LEN_W-1:0] len,
                                        input logic [PAT_W-1:0] win);
        logic m;
        logic all_eq;
        m = 1'b0;
        for (int l = 1; l <= PAT_BYTES; l++) begin
            all_eq = 1'b1;
            for (int k = 0; k < l; k++) begin
                if (pat[8*k +: 8] != win[8*(l-1-k) +: 8]) begin
                    all_eq = 1'b0;
                end
            end
            if ((len == LEN_W'(l)) && all_eq) begin
                m = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/core/multi_pattern_substring_screen.sv
// Multi-pattern substring screen.
// Input channel s_*: one transfer per item. s_tuser selects add pattern, scan
// byte, end of empty message or clear added patterns; s_tlast marks the last
// byte of a message. Result channel m_*: one transfer for each add, clear and
// message end; scan bytes that are not last give no result.
// Each pattern lives in one cell of a chain; all cells compare against the
// byte window in parallel as each scan byte is taken. Adds and clears give
// their result in the next cycle.
// At a message end the per-cell hit flags are shifted toward cell 0, one cell
// per cycle, and the first flag to arrive gives the lowest matching index.
// The sweep stops at the first hit or at the last entry, and no input is
// taken meanwhile.
// Results sit in an output register: while a result is held and m_tready is
// low, no input is taken at all; a sweep that finishes waits for the
// register to drain.
// Reset loads the six built-in patterns, sets the count to six and empties
// the message state; no clearing pass is needed.
module multi_pattern_substring_screen
    import mpss_pkg::*;
#(
    parameter int MAX_PATTERNS = DEF_MAX_PATTERNS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // data_byte[7:0], pattern_bytes[71:8], pattern_length[75:72]
    input  logic        s_tlast,   // is_last
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // hit_index[5:0], entry_count[12:6]
    output logic [2:0]  m_tuser    // kind
);

    localparam int IDX_W = $clog2(MAX_PATTERNS);
    localparam int CNT_W = $clog2(MAX_PATTERNS + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PAT_W-1:0]  window_reg, window_next;
    logic [IDX_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic              m_valid_reg;
    logic [2:0]        m_kind_reg;
    logic [5:0]        m_idx_reg;
    logic [6:0]        m_cnt_reg;

    logic [1:0]        in_mode;
    logic [7:0]        in_byte;
    logic [PAT_W-1:0]  in_pattern;
    logic [LEN_W-1:0]  in_len;
    logic [LEN_W-1:0]  stored_len;
    logic [PAT_W-1:0]  window_shift;

    logic              accept;
    logic              slot_free;
    logic              table_full;
    logic              table_clear;
    logic              add_en;
    logic              load_out;
    logic [2:0]        kind_n;
    logic [IDX_W-1:0]  idx_n;
    logic [IDX_W-1:0]  last_idx;
    logic              sweep_done;
    cell_ctl_t         ctl;

    logic [IDX_W+5:0]  idx_ext;
    logic [CNT_W+6:0]  cnt_ext;

    logic [MAX_PATTERNS-1:0] hit_vec;
    logic [MAX_PATTERNS-1:0] shift_vec;
    logic [MAX_PATTERNS-1:0] valid_vec;

    assign in_mode    = s_tuser;
    assign in_byte    = s_tdata[7:0];
    assign in_pattern = s_tdata[71:8];
    assign in_len     = s_tdata[75:72];
    assign stored_len = pattern_len(in_pattern, in_len);

    assign window_shift = {window_reg[PAT_W-9:0], in_byte};
    assign accept       = s_tvalid && s_tready;
    assign slot_free    = !m_valid_reg || m_tready;
    assign table_full   = (count_reg == CNT_W'(MAX_PATTERNS));
    assign last_idx     = IDX_W'(count_reg - CNT_W'(1));
    assign sweep_done   = hit_vec[0] || (sweep_cnt_reg == last_idx);
    assign shift_vec    = {1'b0, hit_vec[MAX_PATTERNS-1:1]};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERNS; gi++) begin : g_cell
            assign valid_vec[gi] = (CNT_W'(gi) < count_reg);

            mpss_cell #(
                .INDEX(gi)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .entry_valid(valid_vec[gi]),
                .wr_en      (add_en && (count_reg == CNT_W'(gi))),
                .wr_pattern (in_pattern),
                .wr_len     (stored_len),
                .window     (window_shift),
                .shift_in   (shift_vec[gi]),
                .hit        (hit_vec[gi])
            );
        end
    endgenerate

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && ((in_mode == MODE_END) || ((in_mode == MODE_SCAN) && s_tlast))) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (sweep_done && slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        s_tready    = 1'b0;
        ctl         = '0;
        add_en      = 1'b0;
        table_clear = 1'b0;
        load_out    = 1'b0;
        kind_n      = KIND_CLEAN;
        idx_n       = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = slot_free;
                if (accept) begin
                    case (in_mode)
                        MODE_ADD: begin
                            load_out = 1'b1;
                            if (table_full) begin
                                kind_n = KIND_FULL;
                            end else begin
                                add_en = 1'b1;
                                kind_n = KIND_ADDED;
                            end
                        end
                        MODE_SCAN: begin
                            ctl.scan = 1'b1;
                        end
                        MODE_CLEAR: begin
                            ctl.clear   = 1'b1;
                            table_clear = 1'b1;
                            load_out    = 1'b1;
                            kind_n      = KIND_CLEARED;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (sweep_done) begin
                    if (slot_free) begin
                        load_out  = 1'b1;
                        ctl.clear = 1'b1;
                        kind_n    = hit_vec[0] ? KIND_HIT : KIND_CLEAN;
                        idx_n     = hit_vec[0] ? sweep_cnt_reg : '0;
                    end
                end else begin
                    ctl.shift = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        count_next     = count_reg;
        window_next    = window_reg;
        sweep_cnt_next = sweep_cnt_reg;
        if (add_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (table_clear) begin
            count_next = CNT_W'(BUILTIN_COUNT);
        end
        // An end transfer closes the message too, so its bytes never reach the next one.
        if (table_clear || (accept && (in_mode == MODE_END))) begin
            window_next = '0;
        end else if (ctl.scan) begin
            window_next = s_tlast ? '0 : window_shift;
        end
        if (state_reg == ST_IDLE) begin
            sweep_cnt_next = '0;
        end else if (ctl.shift) begin
            sweep_cnt_next = sweep_cnt_reg + IDX_W'(1);
        end
    end

    assign idx_ext = {6'd0, idx_n};
    assign cnt_ext = {7'd0, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_W'(BUILTIN_COUNT);
            window_reg    <= '0;
            sweep_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            window_reg    <= window_next;
            sweep_cnt_reg <= sweep_cnt_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_kind_reg <= kind_n;
            m_idx_reg  <= idx_ext[5:0];
            m_cnt_reg  <= cnt_ext[6:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {3'd0, m_cnt_reg, m_idx_reg};

    // Hit flags only ever sit in cells that hold a live entry.
    a_hits_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (hit_vec & ~valid_vec) == '0)
        else $error("hit flag set beyond the entry count");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(BUILTIN_COUNT)) && (count_reg <= CNT_W'(MAX_PATTERNS)))
        else $error("entry count out of range");

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (sweep_cnt_reg <= last_idx))
        else $error("sweep ran past the last entry");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_mode == MODE_ADD) && table_full)
        |=> (m_tvalid && (m_tuser == KIND_FULL) && (m_tdata[12:6] == $past(cnt_ext[6:0]))))
        else $error("add to a full table did not report full");

endmodule

// File: rtl/core/mpss_cell.sv
module mpss_cell
    import mpss_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctl_t        ctl,
    input  logic             entry_valid,
    input  logic             wr_en,
    input  logic [PAT_W-1:0] wr_pattern,
    input  logic [LEN_W-1:0] wr_len,
    input  logic [PAT_W-1:0] window,
    input  logic             shift_in,
    output logic             hit
);

    logic [PAT_W-1:0] pattern_reg;
    logic [LEN_W-1:0] len_reg;
    logic             hit_reg;
    logic             match;

    assign match = cell_match(pattern_reg, len_reg, window);
    assign hit   = hit_reg;

    // Built-in entries come up loaded; the others hold nothing until an add writes them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            if (INDEX < BUILTIN_COUNT) begin
                pattern_reg <= builtin_pat(INDEX);
                len_reg     <= builtin_len(INDEX);
            end
        end else if (wr_en) begin
            pattern_reg <= wr_pattern;
            len_reg     <= wr_len;
        end
    end

    // The hit flag is sticky for the message and moves one cell down per sweep step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (ctl.clear) begin
            hit_reg <= 1'b0;
        end else if (ctl.shift) begin
            hit_reg <= shift_in;
        end else if (ctl.scan && entry_valid && match) begin
            hit_reg <= 1'b1;
        end
    end

endmodule

// File: test/multi_pattern_substring_screen_tb.sv
`timescale 1ns / 100ps

module multi_pattern_substring_screen_tb;
    import mpss_pkg::*;

    localparam int ITEM_GOAL  = 1950;
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_WAIT  = 100;

    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  data_byte;
        logic        is_last;
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        bit          drain_first;
    } screen_req_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] hit_index;
        logic [6:0] entry_count;
    } screen_verdict_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    multi_pattern_substring_screen u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Screen state mirrored by the predictor.
    logic [63:0] pat_word [DEF_MAX_PATTERNS];
    logic [3:0]  pat_len  [DEF_MAX_PATTERNS];
    int unsigned entries_held;
    logic [63:0] recent_bytes;     // byte 0 is the newest
    int unsigned recent_count;
    bit          msg_hit;
    int unsigned msg_first;

    screen_req_t     pending_req [$];
    screen_verdict_t verdict_fifo [$];

    // Patterns known to the generator, so messages can carry them.
    logic [63:0] pool_word [$];
    logic [3:0]  pool_len  [$];
    bit          drain_next;

    string builtin_text [BUILTIN_COUNT] = '{";rm", "|sh", "../", "%n", "#include", "#define"};

    int unsigned fail_count;
    int unsigned items_taken;
    int unsigned results_seen;
    int unsigned kind_seen [5];
    int unsigned peak_entries;

    function automatic logic [63:0] text_word(input string s);
        logic [63:0] w;
        w = '0;
        for (int k = 0; k < s.len() && k < PAT_BYTES; k++) begin
            w[8*k +: 8] = s[k];
        end
        return w;
    endfunction

    function automatic void forget_message();
        recent_bytes = '0;
        recent_count = 0;
        msg_hit      = 1'b0;
        msg_first    = 0;
    endfunction

    // Applies one accepted transfer to the mirrored state; returns 1 when it yields a result.
    function automatic bit screen_step(input screen_req_t rq, output screen_verdict_t v);
        logic [63:0] w;
        int unsigned n;
        int unsigned k;
        bit          same;
        v = '0;
        case (rq.mode)
            MODE_ADD: begin
                if (entries_held >= DEF_MAX_PATTERNS) begin
                    v.kind        = KIND_FULL;
                    v.entry_count = 7'(entries_held);
                    return 1'b1;
                end
                n = (rq.pattern_length > PAT_BYTES) ? PAT_BYTES : rq.pattern_length;
                w = '0;
                k = 0;
                while (k < n && rq.pattern_bytes[8*k +: 8] != 8'd0) begin
                    w[8*k +: 8] = rq.pattern_bytes[8*k +: 8];
                    k++;
                end
                pat_word[entries_held] = w;
                pat_len[entries_held]  = 4'(k);
                entries_held++;
                v.kind        = KIND_ADDED;
                v.entry_count = 7'(entries_held);
                return 1'b1;
            end
            MODE_CLEAR: begin
                entries_held = BUILTIN_COUNT;
                forget_message();
                v.kind        = KIND_CLEARED;
                v.entry_count = 7'(entries_held);
                return 1'b1;
            end
            MODE_SCAN: begin
                recent_bytes = {recent_bytes[55:0], rq.data_byte};
                if (recent_count < PAT_BYTES) begin
                    recent_count++;
                end
                // Once a hit is known only lower indices can still improve it.
                for (int i = 0; i < entries_held; i++) begin
                    if (msg_hit && i >= msg_first) break;
                    n = pat_len[i];
                    if (n == 0 || n > recent_count) continue;
                    same = 1'b1;
                    for (k = 0; k < n; k++) begin
                        if (pat_word[i][8*k +: 8] != recent_bytes[8*(n-1-k) +: 8]) begin
                            same = 1'b0;
                        end
                    end
                    if (same) begin
                        msg_hit   = 1'b1;
                        msg_first = i;
                        break;
                    end
                end
                if (!rq.is_last) begin
                    return 1'b0;
                end
            end
            default: begin
            end
        endcase
        v.kind        = msg_hit ? KIND_HIT : KIND_CLEAN;
        v.hit_index   = msg_hit ? 6'(msg_first) : 6'd0;
        v.entry_count = 7'(entries_held);
        forget_message();
        return 1'b1;
    endfunction

    task automatic queue_req(input logic [1:0] mode, input logic [7:0] b, input logic last,
                             input logic [63:0] pbytes, input logic [3:0] plen);
        screen_req_t rq;
        rq.mode           = mode;
        rq.data_byte      = b;
        rq.is_last        = last;
        rq.pattern_bytes  = pbytes;
        rq.pattern_length = plen;
        rq.drain_first    = drain_next;
        drain_next        = 1'b0;
        pending_req.push_back(rq);
    endtask

    task automatic queue_scan(input logic [7:0] b, input logic last);
        queue_req(MODE_SCAN, b, last, {$urandom, $urandom}, 4'($urandom_range(0, 15)));
    endtask

    task automatic queue_add(input logic [63:0] pbytes, input logic [3:0] plen);
        queue_req(MODE_ADD, 8'($urandom_range(0, 255)), 1'($urandom), pbytes, plen);
        pool_word.push_back(pbytes);
        pool_len.push_back(plen);
    endtask

    task automatic queue_ctl(input logic [1:0] mode);
        queue_req(mode, 8'($urandom_range(0, 255)), 1'($urandom), {$urandom, $urandom},
                  4'($urandom_range(0, 15)));
    endtask

    task automatic queue_text(input string s, input logic last);
        for (int k = 0; k < s.len(); k++) begin
            queue_scan(s[k], last && (k == s.len() - 1));
        end
    endtask

    task automatic gen_add();
        logic [63:0] w;
        logic [3:0]  n;
        int unsigned sel;
        w   = {$urandom, $urandom};
        n   = 4'($urandom_range(0, 15));
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            // Short text over a small alphabet, so that messages hit it now and then.
            w = '0;
            n = 4'($urandom_range(1, 4));
            for (int k = 0; k < n; k++) begin
                w[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 7));
            end
        end else if (sel == 6) begin
            w[8*$urandom_range(0, 7) +: 8] = 8'd0;
        end
        queue_add(w, n);
    endtask

    // A message of about nbytes bytes; an empty one is sent as a lone end transfer.
    task automatic gen_message(input int unsigned nbytes);
        logic [7:0]  msg [$];
        logic [7:0]  b;
        int unsigned pick;
        if (nbytes == 0) begin
            queue_ctl(MODE_END);
            return;
        end
        while (msg.size() < nbytes) begin
            if ($urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, pool_word.size() - 1);
                for (int k = 0; k < PAT_BYTES && k < pool_len[pick]; k++) begin
                    b = pool_word[pick][8*k +: 8];
                    if (b == 8'd0) break;
                    msg.push_back(b);
                end
                // Sometimes cut the pattern short so it only nearly matches.
                if ($urandom_range(0, 3) == 0 && msg.size() > 0) begin
                    void'(msg.pop_back());
                end
            end else if ($urandom_range(0, 1) == 0) begin
                msg.push_back(8'h61 + 8'($urandom_range(0, 7)));
            end else begin
                msg.push_back(8'($urandom_range(0, 255)));
            end
        end
        for (int j = 0; j < msg.size(); j++) begin
            queue_scan(msg[j], j == msg.size() - 1);
            if (j != msg.size() - 1) begin
                if ($urandom_range(0, 39) == 0) begin
                    gen_add();
                end else if ($urandom_range(0, 149) == 0) begin
                    queue_ctl(MODE_CLEAR);
                end
            end
        end
    endtask

    task automatic note_mismatch(input string what, input screen_verdict_t want,
                                 input screen_verdict_t got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("Result %0d %s: expected kind %0d index %0d count %0d, got kind %0d index %0d count %0d",
                     results_seen, what, want.kind, want.hit_index, want.entry_count,
                     got.kind, got.hit_index, got.entry_count);
        end
    endtask

    // Driver.
    screen_req_t     cur_req;
    bit              have_req;
    bit              offer;
    int unsigned     gap_left;
    screen_verdict_t predicted;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            have_req = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (screen_step(cur_req, predicted)) begin
                    verdict_fifo.push_back(predicted);
                end
                items_taken++;
                have_req = 1'b0;
            end
            if (!have_req && pending_req.size() != 0) begin
                cur_req  = pending_req.pop_front();
                have_req = 1'b1;
                gap_left = ((items_taken % 300) < 40) ? 0 : $urandom_range(0, 9);
            end
            offer = 1'b0;
            if (have_req) begin
                if (cur_req.drain_first && verdict_fifo.size() != 0) begin
                    offer = 1'b0;
                end else if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    offer = 1'b1;
                end
            end
            s_tvalid <= offer;
            s_tdata  <= {4'b0, cur_req.pattern_length, cur_req.pattern_bytes, cur_req.data_byte};
            s_tlast  <= cur_req.is_last;
            s_tuser  <= cur_req.mode;
        end
    end

    // Monitor and result-side backpressure.
    screen_verdict_t got;
    screen_verdict_t want;
    int unsigned     rx_wait;
    int unsigned     hold_left;
    bit              ready_next;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait   = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.kind        = m_tuser;
                got.hit_index   = m_tdata[5:0];
                got.entry_count = m_tdata[12:6];
                if (verdict_fifo.size() == 0) begin
                    note_mismatch("with nothing outstanding", '0, got);
                end else begin
                    want = verdict_fifo.pop_front();
                    if (want.kind <= KIND_CLEARED) begin
                        kind_seen[want.kind]++;
                    end
                    if (want.entry_count > peak_entries) begin
                        peak_entries = want.entry_count;
                    end
                    if (got.kind !== want.kind || got.hit_index !== want.hit_index ||
                        got.entry_count !== want.entry_count) begin
                        note_mismatch("differs", want, got);
                    end
                end
                rx_wait = ((results_seen % 150) < 20) ? 0 : $urandom_range(0, 9);
                // Long hold-offs let the block fill up and stall its input.
                if (results_seen == 60 || results_seen == 300) begin
                    hold_left = 300;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    // Watchdog on cycles with no transfer on either side.
    int unsigned idle_cycles;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("multi_pattern_substring_screen_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [63:0] tail_word;
        int unsigned sel;
        int unsigned next_drain;
        bit          fill_done;

        for (int i = 0; i < BUILTIN_COUNT; i++) begin
            pat_word[i] = text_word(builtin_text[i]);
            pat_len[i]  = 4'(builtin_text[i].len());
            pool_word.push_back(pat_word[i]);
            pool_len.push_back(pat_len[i]);
        end
        entries_held = BUILTIN_COUNT;
        forget_message();

        // Directed opening.
        queue_ctl(MODE_END);
        queue_text("%n", 1'b1);
        queue_text("|sh", 1'b1);
        queue_text("../;rm", 1'b1);                  // lower index wins over the earlier match
        queue_add(text_word("ABCDEFGH"), 4'd12);     // length beyond the pattern width
        queue_add(64'h0000_0000_7A00_7978, 4'd4);    // zero byte cuts the pattern to "xy"
        queue_add({$urandom, $urandom}, 4'd0);       // empty pattern, never matches
        queue_add('1, 4'd15);
        queue_scan("q", 1'b0);
        queue_add(text_word("qz"), 4'd2);            // added mid-message, still sees "q"
        queue_scan("z", 1'b1);
        queue_text("%", 1'b1);
        queue_text("n", 1'b1);                       // no match across a message boundary
        queue_text(";r", 1'b0);
        queue_ctl(MODE_CLEAR);                       // drops the message in progress
        queue_text("m", 1'b1);
        queue_scan(8'h00, 1'b0);
        queue_scan(8'hFF, 1'b1);

        next_drain = 500;
        fill_done  = 1'b0;
        while (pending_req.size() < ITEM_GOAL) begin
            if (!fill_done && pending_req.size() >= 800) begin
                // Fill the table to the last entry, then try a few more adds.
                drain_next = 1'b1;
                queue_ctl(MODE_CLEAR);
                for (int j = BUILTIN_COUNT; j < DEF_MAX_PATTERNS - 1; j++) begin
                    queue_add({$urandom, $urandom} | 64'h0101_0101_0101_0101,
                              4'($urandom_range(5, 8)));
                end
                tail_word = {$urandom, $urandom} | 64'h8080_8080_8080_8080;
                queue_add(tail_word, 4'd8);
                for (int j = 0; j < 3; j++) begin
                    gen_add();
                end
                for (int k = 0; k < PAT_BYTES; k++) begin
                    queue_scan(tail_word[8*k +: 8], k == PAT_BYTES - 1);
                end
                for (int j = 0; j < 6; j++) begin
                    gen_message($urandom_range(4, 12));
                end
                fill_done = 1'b1;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    gen_message(($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                            : $urandom_range(1, 8));
                end else if (sel < 82) begin
                    gen_add();
                end else if (sel < 86) begin
                    queue_ctl(MODE_CLEAR);
                end else begin
                    gen_message(0);
                end
            end
            if (pending_req.size() >= next_drain) begin
                drain_next = 1'b1;
                next_drain += 500;
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_req.size() != 0 || have_req || verdict_fifo.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_WAIT) @(posedge aclk);

        if (verdict_fifo.size() != 0) begin
            $display("%0d expected results never arrived", verdict_fifo.size());
            fail_count += verdict_fifo.size();
        end
        $display("Screened %0d messages (%0d hits, %0d clean) over %0d input transfers",
                 kind_seen[KIND_HIT] + kind_seen[KIND_CLEAN], kind_seen[KIND_HIT],
                 kind_seen[KIND_CLEAN], items_taken);
        $display("Table traffic: %0d adds, %0d refused when full, %0d clears, peak %0d entries",
                 kind_seen[KIND_ADDED], kind_seen[KIND_FULL], kind_seen[KIND_CLEARED],
                 peak_entries);
        if (fail_count == 0) begin
            $display("multi_pattern_substring_screen_tb OK");
        end else begin
            $display("multi_pattern_substring_screen_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/mpss_pkg.sv
rtl/core/mpss_cell.sv
rtl/core/multi_pattern_substring_screen.sv
test/multi_pattern_substring_screen_tb.sv
